>>> design/bpt_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Bytecode position table package
// Shared widths, depths, status codes and controller types.
// ----------------------------------------------------------------------------
package bpt_pkg;

   localparam int CODE_DEPTH   = 4096;
   localparam int SOURCE_DEPTH = 256;
   localparam int POS_DEPTH    = 1024;

   localparam int CODE_AW = $clog2(CODE_DEPTH);
   localparam int SRC_AW  = $clog2(SOURCE_DEPTH);
   localparam int POS_AW  = $clog2(POS_DEPTH);

   localparam int OFF_W  = 12;
   localparam int LINE_W = 20;
   localparam int COL_W  = 16;
   localparam int ID_W   = 16;

   typedef enum logic [1:0] {
      STATUS_OK      = 2'd0,
      STATUS_FULL    = 2'd1,
      STATUS_NO_POS  = 2'd2,
      STATUS_UNUSED  = 2'd3
   } status_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_WR_READ,
      ST_WR_SRC,
      ST_WR_POS,
      ST_LK_STEP,
      ST_LK_WAIT,
      ST_LK_ENTRY,
      ST_LK_SRC,
      ST_LK_DONE,
      ST_OUT
   } state_type;

   typedef struct packed {
      logic load;
      logic wr_read;
      logic wr_src;
      logic wr_pos;
      logic lk_issue;
      logic lk_update;
      logic lk_entry;
      logic lk_src;
      logic lk_finish;
      logic out_valid;
   } cmd_type;

   typedef struct packed {
      logic is_lookup;
      logic code_full;
      logic lk_trivial;
      logic lk_more;
   } stat_type;

endpackage

`default_nettype wire

>>> design/bytecode_position_table_unit.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Bytecode position table unit
// Appends code bytes with deduplicated source positions and looks up the
// source position of an instruction offset by binary search.
// ----------------------------------------------------------------------------
// One transaction is handled at a time. An append steps through the read,
// source and position states to the result, or goes straight to the result
// when the code store is full; a lookup is paced by the single read port of
// the position memory, through which the binary search issues one probe at a
// time. A lookup with positions disabled or an empty table goes straight to
// the result. The input stays stalled until the result has been taken, and
// the next transaction is accepted in the cycle after that at the earliest.
module bytecode_position_table_unit (
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          csr_write,
   input  wire logic          csr_data,
   input  wire logic          req_valid,
   output logic               req_stall,
   input  wire logic          req_action,
   input  wire logic [7:0]    req_code_byte,
   input  wire logic [19:0]   req_line,
   input  wire logic [15:0]   req_col,
   input  wire logic [15:0]   req_file_id,
   input  wire logic [15:0]   req_line_start_id,
   input  wire logic [11:0]   req_inst_offset,
   output logic               rsp_valid,
   input  wire logic          rsp_stall,
   output logic [1:0]         rsp_status,
   output logic [11:0]        rsp_write_offset,
   output logic [11:0]        rsp_pos_offset,
   output logic [19:0]        rsp_pos_line,
   output logic [15:0]        rsp_pos_col,
   output logic [15:0]        rsp_pos_file_id,
   output logic [15:0]        rsp_pos_line_start_id,
   output logic               rsp_pos_known
);

   bpt_pkg::cmd_type  cmd;
   bpt_pkg::stat_type stat;

   bpt_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_stall (rsp_stall),
      .stat      (stat),
      .cmd       (cmd)
   );

   bpt_datapath u_datapath (
      .clock                 (clock),
      .reset                 (reset),
      .cmd                   (cmd),
      .stat                  (stat),
      .csr_write             (csr_write),
      .csr_data              (csr_data),
      .req_action            (req_action),
      .req_code_byte         (req_code_byte),
      .req_line              (req_line),
      .req_col               (req_col),
      .req_file_id           (req_file_id),
      .req_line_start_id     (req_line_start_id),
      .req_inst_offset       (req_inst_offset),
      .rsp_status            (rsp_status),
      .rsp_write_offset      (rsp_write_offset),
      .rsp_pos_offset        (rsp_pos_offset),
      .rsp_pos_line          (rsp_pos_line),
      .rsp_pos_col           (rsp_pos_col),
      .rsp_pos_file_id       (rsp_pos_file_id),
      .rsp_pos_line_start_id (rsp_pos_line_start_id),
      .rsp_pos_known         (rsp_pos_known)
   );

   assign rsp_valid = cmd.out_valid;

endmodule

`default_nettype wire

>>> design/bpt_ctrl.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Bytecode position table controller
// Sequences appends and binary-search lookups through the datapath.
// ----------------------------------------------------------------------------
module bpt_ctrl (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   output logic                   req_stall,
   input  wire logic              rsp_stall,
   input  wire bpt_pkg::stat_type stat,
   output bpt_pkg::cmd_type       cmd
);

   bpt_pkg::state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= bpt_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         bpt_pkg::ST_IDLE: begin
            if (req_valid) begin
               state_in = bpt_pkg::ST_WR_READ;
            end
         end
         bpt_pkg::ST_WR_READ: begin
            if (stat.is_lookup) begin
               state_in = stat.lk_trivial ? bpt_pkg::ST_OUT : bpt_pkg::ST_LK_STEP;
            end else if (stat.code_full) begin
               state_in = bpt_pkg::ST_OUT;
            end else begin
               state_in = bpt_pkg::ST_WR_SRC;
            end
         end
         bpt_pkg::ST_WR_SRC:   state_in = bpt_pkg::ST_WR_POS;
         bpt_pkg::ST_WR_POS:   state_in = bpt_pkg::ST_OUT;
         bpt_pkg::ST_LK_STEP: begin
            state_in = stat.lk_more ? bpt_pkg::ST_LK_WAIT : bpt_pkg::ST_LK_ENTRY;
         end
         bpt_pkg::ST_LK_WAIT:  state_in = bpt_pkg::ST_LK_STEP;
         bpt_pkg::ST_LK_ENTRY: state_in = bpt_pkg::ST_LK_SRC;
         bpt_pkg::ST_LK_SRC:   state_in = bpt_pkg::ST_LK_DONE;
         bpt_pkg::ST_LK_DONE:  state_in = bpt_pkg::ST_OUT;
         bpt_pkg::ST_OUT: begin
            if (!rsp_stall) begin
               state_in = bpt_pkg::ST_IDLE;
            end
         end
         default:              state_in = bpt_pkg::ST_IDLE;
      endcase
   end

   always_comb begin
      cmd       = '0;
      req_stall = 1'b1;
      case (state_ff)
         bpt_pkg::ST_IDLE: begin
            req_stall = 1'b0;
            cmd.load  = req_valid;
         end
         bpt_pkg::ST_WR_READ: begin
            cmd.wr_read  = !stat.is_lookup && !stat.code_full;
            cmd.lk_issue = stat.is_lookup && !stat.lk_trivial;
         end
         bpt_pkg::ST_WR_SRC:   cmd.wr_src = 1'b1;
         bpt_pkg::ST_WR_POS:   cmd.wr_pos = 1'b1;
         bpt_pkg::ST_LK_STEP:  cmd.lk_update = 1'b1;
         bpt_pkg::ST_LK_WAIT:  cmd.lk_issue = 1'b1;
         bpt_pkg::ST_LK_ENTRY: cmd.lk_entry = 1'b1;
         bpt_pkg::ST_LK_SRC:   cmd.lk_src = 1'b1;
         bpt_pkg::ST_LK_DONE:  cmd.lk_finish = 1'b1;
         bpt_pkg::ST_OUT:      cmd.out_valid = 1'b1;
         default:              cmd = '0;
      endcase
   end

endmodule

`default_nettype wire

>>> design/bpt_datapath.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Bytecode position table datapath
// Code, source and position memories, counters, search bounds and result.
// ----------------------------------------------------------------------------
module bpt_datapath (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire bpt_pkg::cmd_type            cmd,
   output bpt_pkg::stat_type                stat,
   input  wire logic                        csr_write,
   input  wire logic                        csr_data,
   input  wire logic                        req_action,
   input  wire logic [7:0]                  req_code_byte,
   input  wire logic [bpt_pkg::LINE_W-1:0]  req_line,
   input  wire logic [bpt_pkg::COL_W-1:0]   req_col,
   input  wire logic [bpt_pkg::ID_W-1:0]    req_file_id,
   input  wire logic [bpt_pkg::ID_W-1:0]    req_line_start_id,
   input  wire logic [bpt_pkg::OFF_W-1:0]   req_inst_offset,
   output logic [1:0]                       rsp_status,
   output logic [bpt_pkg::OFF_W-1:0]        rsp_write_offset,
   output logic [bpt_pkg::OFF_W-1:0]        rsp_pos_offset,
   output logic [bpt_pkg::LINE_W-1:0]       rsp_pos_line,
   output logic [bpt_pkg::COL_W-1:0]        rsp_pos_col,
   output logic [bpt_pkg::ID_W-1:0]         rsp_pos_file_id,
   output logic [bpt_pkg::ID_W-1:0]         rsp_pos_line_start_id,
   output logic                             rsp_pos_known
);

   localparam int CODE_AW = bpt_pkg::CODE_AW;
   localparam int SRC_AW  = bpt_pkg::SRC_AW;
   localparam int POS_AW  = bpt_pkg::POS_AW;
   localparam int SRC_W   = bpt_pkg::LINE_W + 2 * bpt_pkg::ID_W;
   localparam int POS_W   = bpt_pkg::OFF_W + SRC_AW + bpt_pkg::COL_W;

   logic [7:0]       code_mem [bpt_pkg::CODE_DEPTH];
   logic [SRC_W-1:0] src_mem  [bpt_pkg::SOURCE_DEPTH];
   logic [POS_W-1:0] pos_mem  [bpt_pkg::POS_DEPTH];

   logic                        en_ff;
   logic [CODE_AW:0]            code_cnt_ff;
   logic [SRC_AW:0]             src_cnt_ff;
   logic [POS_AW:0]             pos_cnt_ff;

   logic                        act_ff;
   logic [7:0]                  byte_ff;
   logic [bpt_pkg::LINE_W-1:0]  line_ff;
   logic [bpt_pkg::COL_W-1:0]   col_ff;
   logic [bpt_pkg::ID_W-1:0]    fid_ff;
   logic [bpt_pkg::ID_W-1:0]    lsid_ff;
   logic [bpt_pkg::OFF_W-1:0]   inst_ff;

   logic [SRC_W-1:0]            src_rd_ff;
   logic [POS_W-1:0]            pos_rd_ff;
   logic [SRC_AW-1:0]           src_addr;
   logic [POS_AW-1:0]           pos_addr;

   logic [POS_AW:0]             lo_ff, lo_in;
   logic [POS_AW:0]             hi_ff, hi_in;
   logic [POS_AW:0]             mid;
   logic [SRC_AW-1:0]           sidx_ff;
   logic                        src_ok_ff;

   logic [1:0]                  status_ff;
   logic [bpt_pkg::OFF_W-1:0]   woff_ff;
   logic [bpt_pkg::OFF_W-1:0]   poff_ff;
   logic [bpt_pkg::LINE_W-1:0]  pline_ff;
   logic [bpt_pkg::COL_W-1:0]   pcol_ff;
   logic [bpt_pkg::ID_W-1:0]    pfid_ff;
   logic [bpt_pkg::ID_W-1:0]    plsid_ff;
   logic                        known_ff;

   logic [SRC_W-1:0]            src_new;
   logic                        src_match;
   logic                        pos_match;
   logic [POS_AW:0]             pos_last;
   logic [POS_AW:0]             lk_idx;
   logic [SRC_AW-1:0]           ent_src;

   assign src_new   = {line_ff, fid_ff, lsid_ff};
   assign src_match = (src_cnt_ff != '0) && (src_rd_ff == src_new);
   assign pos_last  = pos_cnt_ff - 1'b1;
   assign mid       = lo_ff + ((hi_ff - lo_ff) >> 1);
   assign lk_idx    = (lo_ff == '0) ? pos_last : lo_ff - 1'b1;
   assign ent_src   = pos_rd_ff[bpt_pkg::COL_W +: SRC_AW];

   assign stat.is_lookup  = act_ff;
   assign stat.code_full  = code_cnt_ff[CODE_AW];
   assign stat.lk_trivial = !en_ff || (pos_cnt_ff == '0);
   assign stat.lk_more    = lo_in < hi_in;

   always_comb begin
      lo_in = lo_ff;
      hi_in = hi_ff;
      if (pos_rd_ff[POS_W-1 -: bpt_pkg::OFF_W] <= inst_ff) begin
         lo_in = mid + 1'b1;
      end else begin
         hi_in = mid;
      end
   end

   always_comb begin
      src_addr = sidx_ff;
      pos_addr = pos_last[POS_AW-1:0];
      if (cmd.wr_read) begin
         src_addr = src_cnt_ff[SRC_AW-1:0] - 1'b1;
      end else if (cmd.lk_src) begin
         src_addr = ent_src;
      end
      if (cmd.lk_issue) begin
         pos_addr = mid[POS_AW-1:0];
      end else if (cmd.lk_entry) begin
         pos_addr = lk_idx[POS_AW-1:0];
      end
   end

   always_ff @(posedge clock) begin
      src_rd_ff <= src_mem[src_addr];
      pos_rd_ff <= pos_mem[pos_addr];
   end

   always_ff @(posedge clock) begin
      if (cmd.wr_read) begin
         code_mem[code_cnt_ff[CODE_AW-1:0]] <= byte_ff;
      end
      if (cmd.wr_src && en_ff && !src_match && !src_cnt_ff[SRC_AW]) begin
         src_mem[src_cnt_ff[SRC_AW-1:0]] <= src_new;
      end
      if (cmd.wr_pos && en_ff && src_ok_ff && !pos_match && !pos_cnt_ff[POS_AW]) begin
         pos_mem[pos_cnt_ff[POS_AW-1:0]] <= {woff_ff, sidx_ff, col_ff};
      end
   end

   assign pos_match = (pos_cnt_ff != '0) && (ent_src == sidx_ff)
                      && (pos_rd_ff[bpt_pkg::COL_W-1:0] == col_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         en_ff       <= 1'b1;
         code_cnt_ff <= '0;
         src_cnt_ff  <= '0;
         pos_cnt_ff  <= '0;
      end else begin
         if (csr_write) begin
            en_ff <= csr_data;
         end
         if (cmd.wr_read) begin
            code_cnt_ff <= code_cnt_ff + 1'b1;
         end
         if (cmd.wr_src && en_ff && !src_match && !src_cnt_ff[SRC_AW]) begin
            src_cnt_ff <= src_cnt_ff + 1'b1;
         end
         if (cmd.wr_pos && en_ff && src_ok_ff && !pos_match && !pos_cnt_ff[POS_AW]) begin
            pos_cnt_ff <= pos_cnt_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         act_ff    <= req_action;
         byte_ff   <= req_code_byte;
         line_ff   <= req_line;
         col_ff    <= req_col;
         fid_ff    <= req_file_id;
         lsid_ff   <= req_line_start_id;
         inst_ff   <= req_inst_offset;
         lo_ff     <= '0;
         hi_ff     <= pos_cnt_ff;
         status_ff <= bpt_pkg::STATUS_OK;
         woff_ff   <= '0;
         poff_ff   <= req_inst_offset;
         pline_ff  <= '0;
         pcol_ff   <= '0;
         pfid_ff   <= '0;
         plsid_ff  <= '0;
         known_ff  <= 1'b0;
      end
      if (cmd.wr_read) begin
         woff_ff <= bpt_pkg::OFF_W'(code_cnt_ff[CODE_AW-1:0]);
         poff_ff <= '0;
      end
      if (!act_ff && !cmd.load && code_cnt_ff[CODE_AW] && !cmd.wr_src && !cmd.wr_pos
          && !cmd.out_valid) begin
         status_ff <= bpt_pkg::STATUS_FULL;
         poff_ff   <= '0;
      end
      if (cmd.wr_src) begin
         src_ok_ff <= 1'b1;
         if (src_match) begin
            sidx_ff <= src_cnt_ff[SRC_AW-1:0] - 1'b1;
         end else if (!src_cnt_ff[SRC_AW]) begin
            sidx_ff <= src_cnt_ff[SRC_AW-1:0];
         end else begin
            src_ok_ff <= 1'b0;
            if (en_ff) begin
               status_ff <= bpt_pkg::STATUS_NO_POS;
            end
         end
      end
      if (cmd.wr_pos && en_ff && src_ok_ff && !pos_match && pos_cnt_ff[POS_AW]) begin
         status_ff <= bpt_pkg::STATUS_NO_POS;
      end
      if (cmd.lk_update) begin
         lo_ff <= lo_in;
         hi_ff <= hi_in;
      end
      if (cmd.lk_src) begin
         poff_ff <= pos_rd_ff[POS_W-1 -: bpt_pkg::OFF_W];
         pcol_ff <= pos_rd_ff[bpt_pkg::COL_W-1:0];
      end
      if (cmd.lk_finish) begin
         pline_ff <= src_rd_ff[SRC_W-1 -: bpt_pkg::LINE_W];
         pfid_ff  <= src_rd_ff[2*bpt_pkg::ID_W-1 -: bpt_pkg::ID_W];
         plsid_ff <= src_rd_ff[bpt_pkg::ID_W-1:0];
         known_ff <= 1'b1;
      end
   end

   assign rsp_status            = status_ff;
   assign rsp_write_offset      = woff_ff;
   assign rsp_pos_offset        = poff_ff;
   assign rsp_pos_line          = pline_ff;
   assign rsp_pos_col           = pcol_ff;
   assign rsp_pos_file_id       = pfid_ff;
   assign rsp_pos_line_start_id = plsid_ff;
   assign rsp_pos_known         = known_ff;

endmodule

`default_nettype wire
